/* design/npi_pkg.sv */
// Package for the Neville interpolator: shared command and status types, saturation helper.
// No dependencies.
package npi_pkg;
    typedef struct packed {
        logic start_div;   // launch divider with current operands
        logic load_ops;    // latch tableau operands at index
    } npi_cmd_t;

    typedef struct packed {
        logic div_done;
        logic div_zero;
    } npi_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        if (v > 96'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -96'sh80000000) return -32'sh80000000;
        return v[31:0];
    endfunction
endpackage

/* design/neville_polynomial_interpolator_core.sv */
// Top level of the Neville interpolator: controller plus datapath.
// Depends on npi_pkg, npi_control, npi_datapath.
//
// Usage: present sample points (s_point_x, s_point_y) on the input channel,
// one transaction each. The transaction with s_last_point set also carries
// s_query_x and starts evaluation. Up to MAX_POINTS samples are kept; extra
// ones are dropped and reported on m_set_overflow.
// Loading: one point per accepted transaction. Evaluation: a nearest search,
// then n(n-1)/2 tableau entries, each bound by the serial divider plus read
// and update, plus a read and accumulate step per column.
// One result transaction per set; s_ready stays low during evaluation and
// while the result waits, so a stalled receiver holds the block.
// Equal abscissae give zero results with m_duplicate_x set.
// Reset (aresetn, synchronous, active low) empties the set and drops any
// pending result; sample memories keep stale contents that are never read.
module neville_polynomial_interpolator_core import npi_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_query_x,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_interp_value,
    output logic signed [31:0] m_error_estimate,
    output logic               m_duplicate_x,
    output logic               m_set_overflow
);
    localparam int AW = $clog2(MAX_POINTS);

    logic wr_sample, rd_en, cd_init, cd_wr;
    logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b, cd_addr;
    logic signed [31:0] qx, xa_rd, ya_rd, c_rd, d_rd;
    npi_cmd_t cmd;
    npi_sts_t sts;

    npi_control #(.Depth(MAX_POINTS), .AW(AW)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_query_x,
        .s_last_point, .m_valid, .m_ready, .m_interp_value, .m_error_estimate,
        .m_duplicate_x, .m_set_overflow, .wr_sample, .wr_addr, .rd_en,
        .rd_addr_a, .rd_addr_b, .cd_init, .cd_addr, .cd_wr, .qx, .cmd, .sts,
        .xa_rd, .ya_rd, .c_rd, .d_rd
    );

    npi_datapath #(.Depth(MAX_POINTS), .AW(AW)) u_dp (
        .aclk, .aresetn, .wr_sample, .wr_addr, .wr_x(s_point_x),
        .wr_y(s_point_y), .rd_en, .rd_addr_a, .rd_addr_b, .cd_init, .cd_addr,
        .cd_wr, .qx, .cmd, .sts, .xa_rd, .ya_rd, .c_rd, .d_rd
    );
endmodule

/* design/npi_divider.sv */
// Serial restoring divider: signed 49-bit dividend by signed 33-bit divisor,
// truncated toward zero, one quotient bit per cycle. Uses npi_pkg.
module npi_divider import npi_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [48:0]  dividend,
    input  logic signed [32:0]  divisor,
    output logic                done,
    output logic signed [49:0]  quotient
);
    logic [48:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [49:0] rem_reg, rem_next;
    logic [48:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [49:0] trial;

    always_comb begin
        num_next = num_reg; den_next = den_reg; rem_next = rem_reg;
        quo_next = quo_reg; cnt_next = cnt_reg; neg_next = neg_reg;
        busy_next = busy_reg; done_next = 1'b0;
        trial = '0;
        if (start) begin
            num_next  = dividend[48] ? 49'(-dividend) : dividend;
            den_next  = divisor[32] ? 33'(-divisor) : divisor;
            neg_next  = dividend[48] ^ divisor[32];
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'd49;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg[48:0], num_reg[48]};
            num_next = {num_reg[47:0], 1'b0};
            if (trial >= {17'd0, den_reg}) begin
                rem_next = trial - {17'd0, den_reg};
                quo_next = {quo_reg[47:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[47:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next; den_reg <= den_next; rem_reg <= rem_next;
        quo_reg <= quo_next; neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
endmodule

/* design/npi_datapath.sv */
// Datapath: sample and tableau memories, serial divider, product and update logic.
// Uses npi_pkg and npi_divider.
module npi_datapath import npi_pkg::*; #(
    parameter int Depth = 16,
    parameter int AW = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    // controller commands
    input  logic                wr_sample,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_x,
    input  logic signed [31:0]  wr_y,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr_a,
    input  logic [AW-1:0]       rd_addr_b,
    input  logic                cd_init,
    input  logic [AW-1:0]       cd_addr,
    input  logic                cd_wr,
    input  logic signed [31:0]  qx,
    input  npi_cmd_t            cmd,
    output npi_sts_t            sts,
    // read data
    output logic signed [31:0]  xa_rd,
    output logic signed [31:0]  ya_rd,
    output logic signed [31:0]  c_rd,
    output logic signed [31:0]  d_rd
);
    logic signed [31:0] xs_mem [Depth];
    logic signed [31:0] ys_mem [Depth];
    logic signed [31:0] c_mem  [Depth];
    logic signed [31:0] d_mem  [Depth];

    logic signed [31:0] xb_rd;
    logic signed [31:0] c_new, d_new;
    logic signed [32:0] ho_reg, hp_reg;
    logic signed [48:0] dvd;
    logic signed [32:0] dvs;
    logic signed [49:0] quo;
    logic               dv_done;
    logic signed [31:0] q_reg;
    logic signed [65:0] pd, pc;

    always_ff @(posedge aclk) begin
        if (wr_sample) begin
            xs_mem[wr_addr] <= wr_x;
            ys_mem[wr_addr] <= wr_y;
        end
        if (rd_en) begin
            xa_rd <= xs_mem[rd_addr_a];
            ya_rd <= ys_mem[rd_addr_a];
            xb_rd <= xs_mem[rd_addr_b];
            c_rd  <= c_mem[rd_addr_b];
            d_rd  <= d_mem[rd_addr_a];
        end
        if (cd_init) begin
            c_mem[cd_addr] <= ya_rd;
            d_mem[cd_addr] <= ya_rd;
        end else if (cd_wr) begin
            c_mem[cd_addr] <= c_new;
            d_mem[cd_addr] <= d_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_ops) begin
            ho_reg <= 33'(xa_rd) - 33'(qx);
            hp_reg <= 33'(xb_rd) - 33'(qx);
        end
        if (dv_done) q_reg <= sat32(96'(quo));
    end

    // w = c[i+1]-d[i] fits 33 bits; shifted by 16 gives 49 bits
    assign dvd = {(33'(c_rd) - 33'(d_rd)), 16'd0};
    assign dvs = ho_reg - hp_reg;

    npi_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start_div),
        .dividend(dvd), .divisor(dvs), .done(dv_done), .quotient(quo)
    );

    // products truncated toward zero by 2^16
    assign pd = hp_reg * q_reg;
    assign pc = ho_reg * q_reg;
    always_comb begin
        logic signed [65:0] td, tc;
        td = pd + ((pd < 0) ? 66'sd65535 : 66'sd0);
        tc = pc + ((pc < 0) ? 66'sd65535 : 66'sd0);
        d_new = sat32(96'(td >>> 16));
        c_new = sat32(96'(tc >>> 16));
    end

    assign sts = '{div_done: dv_done, div_zero: (dvs == '0)};
endmodule

/* design/npi_control.sv */
// Controller: load sequencing, nearest search, tableau sweep and result handshake.
// Uses npi_pkg; drives npi_datapath.
module npi_control import npi_pkg::*; #(
    parameter int Depth = 16,
    parameter int AW = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_query_x,
    input  logic                s_last_point,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_interp_value,
    output logic signed [31:0]  m_error_estimate,
    output logic                m_duplicate_x,
    output logic                m_set_overflow,
    output logic                wr_sample,
    output logic [AW-1:0]       wr_addr,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr_a,
    output logic [AW-1:0]       rd_addr_b,
    output logic                cd_init,
    output logic [AW-1:0]       cd_addr,
    output logic                cd_wr,
    output logic signed [31:0]  qx,
    output npi_cmd_t            cmd,
    input  npi_sts_t            sts,
    input  logic signed [31:0]  xa_rd,
    input  logic signed [31:0]  ya_rd,
    input  logic signed [31:0]  c_rd,
    input  logic signed [31:0]  d_rd
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_SRD, ST_SCAN, ST_YRD, ST_Y, ST_RD, ST_OPS, ST_DIV, ST_WAIT,
        ST_COL, ST_CRD, ST_ACC, ST_OUT
    } state_t;

    localparam int CW = AW + 1;

    state_t state_reg;
    logic [CW-1:0] n_reg, i_reg, m_reg, near_reg, ns_reg;
    logic          excess_reg, dup_reg, valid_reg;
    logic [32:0]   best_reg;
    logic signed [31:0] qx_reg, y_reg, dy_reg;
    logic [32:0]   diff;
    logic signed [32:0] sd;
    logic          use_c;
    logic signed [32:0] ysum;

    assign qx = qx_reg;
    assign s_ready = (state_reg == ST_LOAD) && !valid_reg;
    assign m_valid = valid_reg;
    assign m_interp_value = y_reg;
    assign m_error_estimate = dy_reg;
    assign m_duplicate_x = dup_reg;
    assign m_set_overflow = excess_reg;

    assign sd   = 33'(qx_reg) - 33'(xa_rd);
    assign diff = sd[32] ? 33'(-sd) : sd;
    assign use_c = ({ns_reg, 1'b0} < (n_reg - m_reg)) || (ns_reg == '0);
    assign ysum = 33'(y_reg) + 33'(use_c ? c_rd : d_rd);

    always_comb begin
        wr_sample = (state_reg == ST_LOAD) && s_valid && s_ready && (n_reg < CW'(Depth));
        wr_addr   = n_reg[AW-1:0];
        rd_en     = 1'b1;
        rd_addr_a = i_reg[AW-1:0];
        rd_addr_b = AW'(i_reg + m_reg);
        cd_init   = (state_reg == ST_SCAN);
        cd_addr   = AW'(i_reg - ((state_reg == ST_SCAN) ? CW'(1) : CW'(0)));
        cd_wr     = (state_reg == ST_COL);
        cmd.load_ops  = (state_reg == ST_OPS);
        cmd.start_div = (state_reg == ST_DIV) && !sts.div_zero;
        if (state_reg == ST_SRD || state_reg == ST_SCAN) begin
            rd_addr_a = i_reg[AW-1:0];
        end
        if (state_reg == ST_CRD) begin
            rd_addr_a = AW'(ns_reg - CW'(1));
            rd_addr_b = ns_reg[AW-1:0];
        end
        if (state_reg == ST_OPS) begin
            rd_addr_b = AW'(i_reg + CW'(1));
        end
        if (state_reg == ST_YRD) begin
            rd_addr_a = near_reg[AW-1:0];
        end
    end

    // ST_RD reads x[i], x[i+m]; ST_OPS latches ho, hp and reads c[i+1], d[i]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            n_reg      <= '0;
            excess_reg <= 1'b0;
            valid_reg  <= 1'b0;
            dup_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (valid_reg) begin
                        if (m_ready) begin
                            valid_reg  <= 1'b0;
                            n_reg      <= '0;
                            excess_reg <= 1'b0;
                        end
                    end else if (s_valid) begin
                        if (n_reg < CW'(Depth)) n_reg <= n_reg + CW'(1);
                        else excess_reg <= 1'b1;
                        if (s_last_point) begin
                            qx_reg    <= s_query_x;
                            i_reg     <= '0;
                            best_reg  <= '1;
                            near_reg  <= '0;
                            dup_reg   <= 1'b0;
                            state_reg <= ST_SRD;
                        end
                    end
                end
                ST_SRD: begin
                    i_reg <= i_reg + CW'(1);
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    // data of index i_reg-1 is present
                    if (diff < best_reg || best_reg == '1) begin
                        best_reg <= diff;
                        near_reg <= i_reg - CW'(1);
                    end
                    if (i_reg == n_reg) state_reg <= ST_YRD;
                    else i_reg <= i_reg + CW'(1);
                end
                ST_YRD: state_reg <= ST_Y;
                ST_Y: begin
                    y_reg  <= ya_rd;
                    dy_reg <= '0;
                    ns_reg <= near_reg;
                    m_reg  <= CW'(1);
                    i_reg  <= '0;
                    state_reg <= (n_reg > CW'(1)) ? ST_RD : ST_OUT;
                end
                ST_RD:  state_reg <= ST_OPS;
                ST_OPS: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (sts.div_zero) begin
                        dup_reg   <= 1'b1;
                        y_reg     <= '0;
                        dy_reg    <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: if (sts.div_done) state_reg <= ST_COL;
                ST_COL: begin
                    if (i_reg + CW'(1) < n_reg - m_reg) begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= ST_RD;
                    end else begin
                        state_reg <= ST_CRD;
                    end
                end
                ST_CRD: state_reg <= ST_ACC;
                ST_ACC: begin
                    dy_reg <= use_c ? c_rd : d_rd;
                    y_reg  <= sat32(96'(ysum));
                    if (!use_c) ns_reg <= ns_reg - CW'(1);
                    if (m_reg + CW'(1) < n_reg) begin
                        m_reg <= m_reg + CW'(1);
                        i_reg <= '0;
                        state_reg <= ST_RD;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    valid_reg <= 1'b1;
                    state_reg <= ST_LOAD;
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule
